// ===== sv/calu_pkg.sv =====
// calu_pkg: shared types, operation codes and status-flag helpers for the
// eight-bit ALU. No dependencies; every other file in sv/ refers to it.
`default_nettype none

package calu_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned ModeW = 4;

  // Status byte bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  typedef logic [DataW-1:0] byte_t;
  typedef logic [ModeW-1:0] mode_t;

  // Operation codes; 14 and 15 mean no operation
  typedef enum logic [ModeW-1:0] {
    ALU_ADD  = 4'd0,
    ALU_SUB  = 4'd1,
    ALU_AND  = 4'd2,
    ALU_OR   = 4'd3,
    ALU_XOR  = 4'd4,
    ALU_CMP  = 4'd5,
    ALU_BIT  = 4'd6,
    ALU_ASL  = 4'd7,
    ALU_LSR  = 4'd8,
    ALU_ROL  = 4'd9,
    ALU_ROR  = 4'd10,
    ALU_INC  = 4'd11,
    ALU_DEC  = 4'd12,
    ALU_PASS = 4'd13
  } alu_op_t;

  // One input word
  typedef struct packed {
    mode_t mode;
    byte_t acc;
    byte_t operand;
    byte_t status_in;
  } alu_item_t;

  // One result word
  typedef struct packed {
    byte_t result;
    byte_t status_out;
  } alu_res_t;

  // Update Z and N from a result byte, keep the other bits
  function automatic byte_t set_zn(input byte_t st, input byte_t v);
    byte_t s;
    s = st;
    s[FlagZ] = (v == '0);
    s[FlagN] = v[DataW-1];
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/calu_if.sv =====
// calu_in_if / calu_out_if: valid-ready channels for the ALU input words and
// result words. Depends on calu_pkg for the payload types.
`default_nettype none

interface calu_in_if;
  logic               valid;
  logic               ready;
  calu_pkg::mode_t    mode;
  calu_pkg::byte_t    acc;
  calu_pkg::byte_t    operand;
  calu_pkg::byte_t    status_in;

  modport source (output valid, mode, acc, operand, status_in, input ready);
  modport sink   (input valid, mode, acc, operand, status_in, output ready);
endinterface

interface calu_out_if;
  logic               valid;
  logic               ready;
  calu_pkg::byte_t    result;
  calu_pkg::byte_t    status_out;

  modport source (output valid, result, status_out, input ready);
  modport sink   (input valid, result, status_out, output ready);
endinterface

`default_nettype wire

// ===== sv/calu_core.sv =====
// calu_core: combinational datapath of the ALU, one word in, one result out.
// Depends on calu_pkg for types, operation codes and flag helpers.
`default_nettype none

module calu_core (
  input  calu_pkg::alu_item_t item,
  output calu_pkg::alu_res_t  res
);

  localparam int unsigned W = calu_pkg::DataW;

  logic [W-1:0] a, m, st, addend, r, st_n;
  logic         cin;
  logic [W:0]   sum;
  logic [W:0]   diff;

  assign a   = item.acc;
  assign m   = item.operand;
  assign st  = item.status_in;
  assign cin = st[calu_pkg::FlagC];

  // Share one adder between add and subtract; subtract adds the inverted byte
  assign addend = (item.mode == calu_pkg::ALU_SUB) ? ~m : m;
  assign sum    = {1'b0, a} + {1'b0, addend} + {{W{1'b0}}, cin};
  assign diff   = {1'b0, a} - {1'b0, m};

  // Select result and flags by operation
  always_comb begin
    r    = a;
    st_n = st;
    unique case (item.mode)
      calu_pkg::ALU_ADD, calu_pkg::ALU_SUB: begin
        r = sum[W-1:0];
        st_n = calu_pkg::set_zn(st, sum[W-1:0]);
        st_n[calu_pkg::FlagC] = sum[W];
        st_n[calu_pkg::FlagV] = ~(a[W-1] ^ addend[W-1]) & (a[W-1] ^ sum[W-1]);
      end
      calu_pkg::ALU_AND: begin
        r = a & m;
        st_n = calu_pkg::set_zn(st, a & m);
      end
      calu_pkg::ALU_OR: begin
        r = a | m;
        st_n = calu_pkg::set_zn(st, a | m);
      end
      calu_pkg::ALU_XOR: begin
        r = a ^ m;
        st_n = calu_pkg::set_zn(st, a ^ m);
      end
      calu_pkg::ALU_CMP: begin
        st_n = calu_pkg::set_zn(st, diff[W-1:0]);
        st_n[calu_pkg::FlagC] = ~diff[W];
      end
      calu_pkg::ALU_BIT: begin
        st_n[calu_pkg::FlagZ] = ((a & m) == '0);
        st_n[calu_pkg::FlagV] = m[calu_pkg::FlagV];
        st_n[calu_pkg::FlagN] = m[calu_pkg::FlagN];
      end
      calu_pkg::ALU_ASL, calu_pkg::ALU_ROL: begin
        r = {m[W-2:0], (item.mode == calu_pkg::ALU_ROL) & cin};
        st_n = calu_pkg::set_zn(st, r);
        st_n[calu_pkg::FlagC] = m[W-1];
      end
      calu_pkg::ALU_LSR, calu_pkg::ALU_ROR: begin
        r = {(item.mode == calu_pkg::ALU_ROR) & cin, m[W-1:1]};
        st_n = calu_pkg::set_zn(st, r);
        st_n[calu_pkg::FlagC] = m[0];
      end
      calu_pkg::ALU_INC: begin
        r = m + W'(1);
        st_n = calu_pkg::set_zn(st, r);
      end
      calu_pkg::ALU_DEC: begin
        r = m - W'(1);
        st_n = calu_pkg::set_zn(st, r);
      end
      calu_pkg::ALU_PASS: begin
        r = m;
        st_n = calu_pkg::set_zn(st, m);
      end
      default: begin
        // Unused codes: no operation, acc and status pass through
        r    = a;
        st_n = st;
      end
    endcase
  end

  assign res.result     = r;
  assign res.status_out = st_n;

endmodule

`default_nettype wire

// ===== sv/cpu_alu_with_status_flags.sv =====
// cpu_alu_with_status_flags: eight-bit ALU with status flags, top level.
// Depends on calu_pkg, calu_if (calu_in_if, calu_out_if) and calu_core.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------
//   in_ch    | in  | valid / ready | mode, acc, operand, status_in
//   out_ch   | out | valid / ready | result, status_out
//
// Path: the input word is captured in the input register, passes the
// single-pass datapath and is then held in the result register, which
// drives out_ch.
// Throughput: one word per cycle while out_ch is not stalled, set by the two-stage register pipeline.
// Reset (rst_n low, synchronous) empties both stages; no configuration.
// A stall at out_ch holds the result register; ready drops only when both
// stages hold a word and out_ch is stalled.
`default_nettype none

module cpu_alu_with_status_flags (
  input  wire logic clk,
  input  wire logic rst_n,
  calu_in_if.sink   in_ch,
  calu_out_if.source out_ch
);

  logic                s1_valid_r;
  calu_pkg::alu_item_t s1_item_r;
  logic                s2_valid_r;
  calu_pkg::alu_res_t  s2_res_r;
  calu_pkg::alu_res_t  core_res;
  logic                s2_take;
  logic                s1_take;
  logic                in_fire;

  // Stage readiness: result stage frees when empty or drained this cycle
  assign s2_take = ~s2_valid_r | out_ch.ready;
  assign s1_take = ~s1_valid_r | s2_take;
  assign in_fire = in_ch.valid & in_ch.ready;

  assign in_ch.ready = s1_take;

  // Input register: hold the word while the next stage is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_fire) begin
      s1_item_r.mode      <= in_ch.mode;
      s1_item_r.acc       <= in_ch.acc;
      s1_item_r.operand   <= in_ch.operand;
      s1_item_r.status_in <= in_ch.status_in;
    end
  end

  calu_core u_core (
    .item (s1_item_r),
    .res  (core_res)
  );

  // Result register: advance when free, drop valid when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_take) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_take && s1_valid_r) begin
      s2_res_r <= core_res;
    end
  end

  assign out_ch.valid      = s2_valid_r;
  assign out_ch.result     = s2_res_r.result;
  assign out_ch.status_out = s2_res_r.status_out;

  // A word held in the input register stays put until it moves on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_take |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage word lost or changed while stalled");

  // Back-pressure only when both stages hold a word
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && s2_valid_r)
    else $error("input refused while a stage is free");

  // Compare leaves the register byte as the result
  a_cmp_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_take && s1_item_r.mode == calu_pkg::ALU_CMP
    |=> s2_res_r.result == $past(s1_item_r.acc))
    else $error("compare changed the result byte");

  // Unused codes pass the status byte through untouched
  a_nop_status: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_take && s1_item_r.mode > calu_pkg::ALU_PASS
    |=> s2_res_r.status_out == $past(s1_item_r.status_in))
    else $error("unused operation changed the status byte");

endmodule

`default_nettype wire
